>>> hw/rtl/ddwc_pkg.sv
// Shared types, constants and calendar functions for the date distance and
// weekday calculator. No dependencies; used by every other file of the block.
`default_nettype none

package ddwc_pkg;

    localparam int YEAR_W   = 15;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int WDAY_W   = 3;
    localparam int DIST_W   = 23;
    localparam int DNUM_W   = 26;  // day numbers and their difference
    localparam int MAG_W    = 25;  // magnitude of a difference
    localparam int MOD_DIGITS = 9; // octal digits that cover a magnitude
    localparam int MOD_W    = 3 * MOD_DIGITS;

    localparam logic signed [YEAR_W-1:0] YEAR_MIN = -15'sd10000;
    localparam logic signed [YEAR_W-1:0] YEAR_MAX = 15'sd12000;
    localparam logic [DIST_W-1:0] DAYS_AWAY_MAX = 23'h7FFFFF;
    localparam logic [WDAY_W-1:0] WEEK_LEN = 3'd7;

    typedef enum logic [1:0] {
        STATUS_SAME    = 2'd0,
        STATUS_FUTURE  = 2'd1,
        STATUS_PAST    = 2'd2,
        STATUS_INVALID = 2'd3
    } ddwc_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC_T,
        ST_CALC_S,
        ST_PREP,
        ST_MOD,
        ST_DONE
    } ddwc_state_t;

    typedef enum logic [1:0] {
        REG_START_YEAR    = 2'd0,
        REG_START_MONTH   = 2'd1,
        REG_START_DAY     = 2'd2,
        REG_START_WEEKDAY = 2'd3
    } ddwc_reg_t;

    typedef struct packed {
        logic load_in;
        logic calc_t;
        logic calc_s;
        logic prep;
        logic mod_step;
        logic load_out;
    } ddwc_cmd_t;

    typedef struct packed {
        logic invalid;
    } ddwc_stat_t;

    function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [8:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] r;
        case (m)
            4'd2:                       r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    r = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:         r = 5'd31;
            default:                    r = 5'd0;
        endcase
        return r;
    endfunction

    // Every year divisible by four is a leap year, negative years included.
    function automatic logic is_leap(input logic signed [YEAR_W-1:0] y);
        return (y[1:0] == 2'b00);
    endfunction

    // Linear day count; month must already be 1..12, day may be 0..31.
    function automatic logic signed [DNUM_W-1:0] day_number(
        input logic signed [YEAR_W-1:0]  y,
        input logic        [MONTH_W-1:0] m,
        input logic        [DAY_W-1:0]   d
    );
        logic signed [DNUM_W-1:0] y_ext;
        logic signed [DNUM_W-1:0] prod;
        logic signed [DNUM_W-1:0] quarter;
        logic signed [DNUM_W-1:0] n;
        y_ext   = DNUM_W'(y);
        prod    = y_ext * 26'sd365;
        // The offset keeps the sum positive so the shift is a true floor.
        quarter = (y_ext + 26'sd20003) >>> 2;
        n = prod + quarter - 26'sd5000
            + $signed({{(DNUM_W-9){1'b0}}, days_before_month(m)})
            + $signed({{(DNUM_W-DAY_W){1'b0}}, d}) - 26'sd1;
        if (m > 4'd2 && is_leap(y)) begin
            n = n + 26'sd1;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ddwc_datapath.sv
// Datapath of the date calculator: input capture, day numbers, difference,
// modulo-7 remainder by octal digit folding and the result register. Uses ddwc_pkg.
`default_nettype none

module ddwc_datapath (
    input  wire logic                               aclk,
    input  wire ddwc_pkg::ddwc_cmd_t                cmd,
    output ddwc_pkg::ddwc_stat_t                    stat,
    input  wire logic signed [ddwc_pkg::YEAR_W-1:0] in_year,
    input  wire logic [ddwc_pkg::MONTH_W-1:0]       in_month,
    input  wire logic [ddwc_pkg::DAY_W-1:0]         in_day,
    input  wire logic signed [ddwc_pkg::YEAR_W-1:0] start_year,
    input  wire logic [ddwc_pkg::MONTH_W-1:0]       start_month,
    input  wire logic [ddwc_pkg::DAY_W-1:0]         start_day,
    input  wire logic [ddwc_pkg::WDAY_W-1:0]        start_weekday,
    output logic [1:0]                              out_status,
    output logic [ddwc_pkg::DIST_W-1:0]             out_days_away,
    output logic [ddwc_pkg::WDAY_W-1:0]             out_weekday
);

    logic signed [ddwc_pkg::YEAR_W-1:0]  ty_reg;
    logic [ddwc_pkg::MONTH_W-1:0]        tm_reg;
    logic [ddwc_pkg::DAY_W-1:0]          td_reg;
    logic signed [ddwc_pkg::DNUM_W-1:0]  dn_t_reg;
    logic signed [ddwc_pkg::DNUM_W-1:0]  diff_reg;
    logic [ddwc_pkg::MAG_W-1:0]          mag_reg;
    logic [ddwc_pkg::DIST_W-1:0]         dist_reg;
    logic                                neg_reg;
    logic                                zero_reg;
    logic                                invalid_reg;
    logic [ddwc_pkg::WDAY_W-1:0]         rem_reg;
    logic [1:0]                          status_reg;
    logic [ddwc_pkg::DIST_W-1:0]         days_reg;
    logic [ddwc_pkg::WDAY_W-1:0]         wday_reg;

    logic [ddwc_pkg::MONTH_W-1:0]        sm_clamped;
    logic signed [ddwc_pkg::YEAR_W-1:0]  dn_y;
    logic [ddwc_pkg::MONTH_W-1:0]        dn_m;
    logic [ddwc_pkg::DAY_W-1:0]          dn_d;
    logic signed [ddwc_pkg::DNUM_W-1:0]  dn_val;
    logic                                target_ok;
    logic [ddwc_pkg::DAY_W-1:0]          tlen;
    logic [ddwc_pkg::MAG_W-1:0]          mag_abs;
    logic [ddwc_pkg::MOD_W-1:0]          mag_pad;
    logic [5:0]                          digit_sum;
    logic [ddwc_pkg::WDAY_W:0]           rem_fold;
    logic [ddwc_pkg::WDAY_W-1:0]         rem_next;
    logic [ddwc_pkg::WDAY_W-1:0]         sw7;
    logic [ddwc_pkg::WDAY_W:0]           wd_sum;
    logic [ddwc_pkg::WDAY_W-1:0]         wd_val;

    always_comb begin
        if (start_month == 4'd0) begin
            sm_clamped = 4'd1;
        end else if (start_month > 4'd12) begin
            sm_clamped = 4'd12;
        end else begin
            sm_clamped = start_month;
        end
        // One day-number unit, shared by target and start date.
        dn_y   = cmd.calc_s ? start_year : ty_reg;
        dn_m   = cmd.calc_s ? sm_clamped : tm_reg;
        dn_d   = cmd.calc_s ? start_day  : td_reg;
        dn_val = ddwc_pkg::day_number(dn_y, dn_m, dn_d);

        tlen      = ddwc_pkg::month_length(tm_reg, ddwc_pkg::is_leap(ty_reg));
        target_ok = (ty_reg >= ddwc_pkg::YEAR_MIN) && (ty_reg <= ddwc_pkg::YEAR_MAX)
                    && (tm_reg inside {[4'd1:4'd12]})
                    && (td_reg >= 5'd1) && (td_reg <= tlen);

        mag_abs = diff_reg[ddwc_pkg::DNUM_W-1] ? ddwc_pkg::MAG_W'(-diff_reg)
                                               : ddwc_pkg::MAG_W'(diff_reg);

        // Eight is one modulo seven, so the octal digits sum to the same remainder.
        mag_pad   = ddwc_pkg::MOD_W'(mag_reg);
        digit_sum = '0;
        for (int i = 0; i < ddwc_pkg::MOD_DIGITS; i++) begin
            digit_sum = digit_sum + 6'(mag_pad[3*i +: 3]);
        end
        rem_fold = {1'b0, digit_sum[5:3]} + {1'b0, digit_sum[2:0]};
        if (rem_fold >= 4'd14) begin
            rem_next = 3'd0;
        end else if (rem_fold >= {1'b0, ddwc_pkg::WEEK_LEN}) begin
            rem_next = ddwc_pkg::WDAY_W'(rem_fold - {1'b0, ddwc_pkg::WEEK_LEN});
        end else begin
            rem_next = ddwc_pkg::WDAY_W'(rem_fold);
        end

        sw7 = (start_weekday == ddwc_pkg::WEEK_LEN) ? 3'd0 : start_weekday;
        // Going back in time subtracts the remainder, going forward adds it.
        if (neg_reg) begin
            wd_sum = {1'b0, sw7} + {1'b0, ddwc_pkg::WEEK_LEN} - {1'b0, rem_reg};
        end else begin
            wd_sum = {1'b0, sw7} + {1'b0, rem_reg};
        end
        wd_val = (wd_sum >= {1'b0, ddwc_pkg::WEEK_LEN})
                 ? ddwc_pkg::WDAY_W'(wd_sum - {1'b0, ddwc_pkg::WEEK_LEN})
                 : ddwc_pkg::WDAY_W'(wd_sum);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            ty_reg <= in_year;
            tm_reg <= in_month;
            td_reg <= in_day;
        end
        if (cmd.calc_t) begin
            dn_t_reg    <= dn_val;
            invalid_reg <= !target_ok;
        end
        if (cmd.calc_s) begin
            diff_reg <= dn_t_reg - dn_val;
        end
        if (cmd.prep) begin
            mag_reg  <= mag_abs;
            neg_reg  <= diff_reg[ddwc_pkg::DNUM_W-1];
            zero_reg <= (diff_reg == '0);
            dist_reg <= (mag_abs > ddwc_pkg::MAG_W'(ddwc_pkg::DAYS_AWAY_MAX))
                        ? ddwc_pkg::DAYS_AWAY_MAX : ddwc_pkg::DIST_W'(mag_abs);
        end
        if (cmd.mod_step) begin
            rem_reg <= rem_next;
        end
        if (cmd.load_out) begin
            if (invalid_reg) begin
                status_reg <= ddwc_pkg::STATUS_INVALID;
                days_reg   <= '0;
                wday_reg   <= '0;
            end else begin
                if (zero_reg) begin
                    status_reg <= ddwc_pkg::STATUS_SAME;
                end else if (neg_reg) begin
                    status_reg <= ddwc_pkg::STATUS_PAST;
                end else begin
                    status_reg <= ddwc_pkg::STATUS_FUTURE;
                end
                days_reg <= dist_reg;
                wday_reg <= wd_val;
            end
        end
    end

    assign stat.invalid  = !target_ok;
    assign out_status    = status_reg;
    assign out_days_away = days_reg;
    assign out_weekday   = wday_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ddwc_ctrl.sv
// Controller of the date calculator: sequences the datapath for one item and
// owns the input ready and output valid flags. Uses ddwc_pkg.
`default_nettype none

module ddwc_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output ddwc_pkg::ddwc_cmd_t      cmd,
    input  wire ddwc_pkg::ddwc_stat_t stat
);

    ddwc_pkg::ddwc_state_t          state_reg, state_next;
    logic                           m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ddwc_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ddwc_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
                if (s_tvalid) begin
                    state_next = ddwc_pkg::ST_CALC_T;
                end
            end
            ddwc_pkg::ST_CALC_T: begin
                cmd.calc_t = 1'b1;
                state_next = stat.invalid ? ddwc_pkg::ST_DONE : ddwc_pkg::ST_CALC_S;
            end
            ddwc_pkg::ST_CALC_S: begin
                cmd.calc_s = 1'b1;
                state_next = ddwc_pkg::ST_PREP;
            end
            ddwc_pkg::ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ddwc_pkg::ST_MOD;
            end
            ddwc_pkg::ST_MOD: begin
                cmd.mod_step = 1'b1;
                state_next   = ddwc_pkg::ST_DONE;
            end
            ddwc_pkg::ST_DONE: begin
                // Wait until the previous result has been taken.
                if (!m_tvalid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ddwc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ddwc_pkg::ST_IDLE;
            end
        endcase
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    a_load_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten while still held");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ddwc_pkg::ST_CALC_T))
        else $error("accepted item did not start the day-number step");

    a_mod_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ddwc_pkg::ST_PREP) |=>
            (state_reg == ddwc_pkg::ST_MOD) ##1 (state_reg == ddwc_pkg::ST_DONE))
        else $error("remainder step did not lead to the done step");

    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ddwc_pkg::ST_DONE))
        else $error("result shown outside the done step");

endmodule

`default_nettype wire

>>> hw/rtl/date_distance_weekday_calc_top.sv
// Each item is a target date; the block returns whether it lies before, on or
// after the configured start date, the distance in days (saturating at
// 8388607) and the target's weekday. After acceptance a valid item passes
// through these steps in order: the target and then the start day number
// on the shared day-number unit, the magnitude, the modulo-7 remainder that
// yields the weekday, and the load of the result. An invalid target goes
// from its day-number step straight to the load of the result. The input is
// ready again in the cycle after the result is loaded. A new item is
// accepted while the last result waits; it then stalls before its own result
// until the waiting one is taken, and no further item is accepted meanwhile.
// Top level: configuration registers and stream packing. Instantiates
// ddwc_ctrl and ddwc_datapath; uses ddwc_pkg.
`default_nettype none

module date_distance_weekday_calc_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // target_year [14:0], target_month [18:15], target_day [23:19]
    input  wire logic [23:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status [1:0], days_away [24:2], target_weekday [27:25], zeros above
    output logic [31:0]      m_tdata,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [14:0] cfg_wr_data
);

    logic signed [ddwc_pkg::YEAR_W-1:0] start_year_reg;
    logic [ddwc_pkg::MONTH_W-1:0]       start_month_reg;
    logic [ddwc_pkg::DAY_W-1:0]         start_day_reg;
    logic [ddwc_pkg::WDAY_W-1:0]        start_weekday_reg;

    ddwc_pkg::ddwc_cmd_t  cmd;
    ddwc_pkg::ddwc_stat_t stat;

    logic [1:0]                  out_status;
    logic [ddwc_pkg::DIST_W-1:0] out_days_away;
    logic [ddwc_pkg::WDAY_W-1:0] out_weekday;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_year_reg    <= 15'sd2022;
            start_month_reg   <= 4'd1;
            start_day_reg     <= 5'd1;
            start_weekday_reg <= 3'd6;
        end else if (cfg_wr_en) begin
            case (ddwc_pkg::ddwc_reg_t'(cfg_addr))
                ddwc_pkg::REG_START_YEAR:    start_year_reg    <= $signed(cfg_wr_data);
                ddwc_pkg::REG_START_MONTH:   start_month_reg   <= cfg_wr_data[3:0];
                ddwc_pkg::REG_START_DAY:     start_day_reg     <= cfg_wr_data[4:0];
                ddwc_pkg::REG_START_WEEKDAY: start_weekday_reg <= cfg_wr_data[2:0];
                default: begin
                end
            endcase
        end
    end

    ddwc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    ddwc_datapath u_datapath (
        .aclk          (aclk),
        .cmd           (cmd),
        .stat          (stat),
        .in_year       ($signed(s_tdata[14:0])),
        .in_month      (s_tdata[18:15]),
        .in_day        (s_tdata[23:19]),
        .start_year    (start_year_reg),
        .start_month   (start_month_reg),
        .start_day     (start_day_reg),
        .start_weekday (start_weekday_reg),
        .out_status    (out_status),
        .out_days_away (out_days_away),
        .out_weekday   (out_weekday)
    );

    assign m_tdata = {4'b0000, out_weekday, out_days_away, out_status};

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for date_distance_weekday_calc_top: each target date is
// predicted in calendar arithmetic and checked against the result stream.
// Depends on ddwc_pkg and the block's RTL only.
`timescale 1ns / 100ps

module testbench;

    localparam int IDLE_LIMIT    = 3000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 92;

    // Result word as it leaves the block, lowest field last.
    typedef struct packed {
        logic [3:0]                  pad;
        logic [ddwc_pkg::WDAY_W-1:0] wday;
        logic [ddwc_pkg::DIST_W-1:0] days;
        ddwc_pkg::ddwc_status_t      status;
    } date_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [14:0] cfg_wr_data;

    // Copy of the start-date registers as the block should hold them.
    logic signed [ddwc_pkg::YEAR_W-1:0] start_year_q;
    logic [ddwc_pkg::MONTH_W-1:0]       start_month_q;
    logic [ddwc_pkg::DAY_W-1:0]         start_day_q;
    logic [ddwc_pkg::WDAY_W-1:0]        start_wday_q;

    date_result_t pending_results[$];
    int           fail_count;
    int           quiet_cycles = 0;
    int           burst_left;
    bit           offering;
    bit           hold_request;

    date_distance_weekday_calc_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int month_days(input int m, input int y);
        if (m == 2) begin
            return ((y & 3) == 0) ? 29 : 28;
        end
        if (m == 4 || m == 6 || m == 9 || m == 11) begin
            return 30;
        end
        return (m >= 1 && m <= 12) ? 31 : 0;
    endfunction

    // Days since a fixed epoch; the constant offset cancels in a difference.
    function automatic longint day_count(input int y, input int m, input int d);
        longint n;
        n = 365 * longint'(y) + (y + 20003) / 4;
        for (int k = 1; k < m; k++) begin
            n += month_days(k, y);
        end
        return n + d;
    endfunction

    function automatic date_result_t predict_distance(input logic [14:0] ty_raw,
                                                      input logic [3:0] tm,
                                                      input logic [4:0] td);
        date_result_t r;
        int           ty;
        int           sm;
        longint       diff;
        longint       span;
        r  = '0;
        ty = int'($signed(ty_raw));
        if (ty < ddwc_pkg::YEAR_MIN || ty > ddwc_pkg::YEAR_MAX || tm < 1 || tm > 12
            || td < 1 || int'(td) > month_days(tm, ty)) begin
            r.status = ddwc_pkg::STATUS_INVALID;
            return r;
        end
        // Out-of-range start months are pinned to January or December.
        sm = (start_month_q < 1) ? 1 : (start_month_q > 12) ? 12 : int'(start_month_q);
        diff = day_count(ty, tm, td) - day_count(int'(start_year_q), sm, start_day_q);
        span = (diff < 0) ? -diff : diff;
        if (span > ddwc_pkg::DAYS_AWAY_MAX) begin
            span = ddwc_pkg::DAYS_AWAY_MAX;
        end
        r.status = (diff == 0) ? ddwc_pkg::STATUS_SAME
                 : (diff > 0) ? ddwc_pkg::STATUS_FUTURE : ddwc_pkg::STATUS_PAST;
        r.days   = span[ddwc_pkg::DIST_W-1:0];
        r.wday   = 3'(((longint'(start_wday_q) % 7) + diff % 7 + 7) % 7);
        return r;
    endfunction

    task automatic sender_quiet();
        if (offering) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    // Offers one target date in bursts with random gaps; returns at acceptance.
    task automatic send_date(input int y, input int m, input int d);
        logic [23:0] item;
        item = {5'(d), 4'(m), 15'(y)};
        if (burst_left == 0) begin
            sender_quiet();
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        offering = 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_distance(item[14:0], item[18:15], item[23:19]));
    endtask

    task automatic write_cfg(input ddwc_pkg::ddwc_reg_t idx, input logic [14:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
    endtask

    // Registers change only once the block has drained and settled.
    task automatic set_start(input int y, input int m, input int d, input int wd);
        sender_quiet();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_cfg(ddwc_pkg::REG_START_YEAR, 15'(y));
        write_cfg(ddwc_pkg::REG_START_MONTH, 15'(4'(m)));
        write_cfg(ddwc_pkg::REG_START_DAY, 15'(5'(d)));
        write_cfg(ddwc_pkg::REG_START_WEEKDAY, 15'(3'(wd)));
        cfg_wr_en <= 1'b0;
        start_year_q  = 15'(y);
        start_month_q = 4'(m);
        start_day_q   = 5'(d);
        start_wday_q  = 3'(wd);
    endtask

    task automatic send_random_date();
        int pick;
        int y;
        int m;
        int d;
        pick = $urandom_range(0, 99);
        m    = $urandom_range(1, 12);
        if (pick < 45) begin
            y = int'(start_year_q) + int'($urandom_range(0, 80)) - 40;
            d = $urandom_range(1, month_days(m, y));
        end else if (pick < 50) begin
            y = start_year_q;
            m = start_month_q;
            d = start_day_q + int'($urandom_range(0, 2)) - 1;
        end else if (pick < 80) begin
            y = int'($urandom_range(0, 22000)) - 10000;
            d = $urandom_range(1, month_days(m, y));
        end else begin
            y = $urandom_range(0, 32767);
            m = $urandom_range(0, 15);
            d = $urandom_range(0, 31);
        end
        send_date(y, m, d);
    endtask

    task automatic test_reset_start();
        send_date(2022, 1, 1);
        send_date(2022, 1, 2);
        send_date(2021, 12, 31);
        send_date(-10000, 1, 1);
        send_date(12000, 12, 31);
        send_date(-10001, 6, 15);
        send_date(12001, 1, 1);
        send_date(-16384, 0, 0);
        send_date(16383, 15, 31);
        send_date(2022, 13, 5);
        send_date(2022, 4, 31);
        send_date(2023, 2, 29);
        send_date(2024, 2, 29);
        send_date(0, 2, 29);
        send_date(-1, 2, 29);
        send_date(-4, 2, 29);
        send_date(2022, 1, 0);
        send_date(2030, 11, 30);
    endtask

    // Start registers beyond their documented ranges: clamped month, linear
    // day, weekday seven and a saturated distance.
    task automatic test_start_extremes();
        set_start(-16384, 0, 0, 7);
        send_date(12000, 12, 31);
        send_date(-10000, 1, 1);
        set_start(16383, 15, 31, 0);
        send_date(-10000, 1, 1);
        send_date(12000, 12, 31);
        set_start(-10000, 13, 31, 3);
        send_date(-10000, 12, 31);
        send_date(12000, 2, 29);
    endtask

    task automatic test_receiver_backpressure();
        set_start(1999, 6, 15, 2);
        hold_request = 1'b1;
        repeat (24) send_random_date();
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 6; phase++) begin
            if (phase % 3 == 2) begin
                set_start($urandom_range(0, 32767), $urandom_range(0, 15),
                          $urandom_range(0, 31), $urandom_range(0, 7));
            end else begin
                set_start(int'($urandom_range(0, 22000)) - 10000, $urandom_range(1, 12),
                          $urandom_range(1, 28), $urandom_range(0, 6));
            end
            repeat (PHASE_ITEMS) send_random_date();
        end
    endtask

    // Receiver: changes stall pattern from time to time, and holds off for a
    // long stretch when asked so that the block backs up into its input.
    initial begin
        int          mode;
        int          mode_left;
        logic [7:0]  rotor;
        mode      = 0;
        mode_left = 0;
        rotor     = 8'b1011_0010;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                rotor = {rotor[6:0], rotor[7]};
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 1);
                    2: m_tready <= rotor[0];
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        date_result_t got;
        date_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                report_field("status", want.status, got.status);
                report_field("days_away", want.days, got.days);
                report_field("target_weekday", want.wday, got.wday);
                report_field("padding", want.pad, got.pad);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        fail_count    = 0;
        burst_left    = 0;
        offering      = 1'b0;
        hold_request  = 1'b0;
        start_year_q  = 15'sd2022;
        start_month_q = 4'd1;
        start_day_q   = 5'd1;
        start_wday_q  = 3'd6;
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= ddwc_pkg::REG_START_YEAR;
        cfg_wr_data <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_start();
        test_start_extremes();
        test_receiver_backpressure();
        test_random_phases();

        sender_quiet();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/ddwc_pkg.sv
hw/rtl/ddwc_datapath.sv
hw/rtl/ddwc_ctrl.sv
hw/rtl/date_distance_weekday_calc_top.sv
bench/testbench.sv
